// File: rtl/core/assert_macros.svh
// Assertion shorthands for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define TSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define TSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/tss_pkg.sv
package tss_pkg;

    // Most sends one tick may produce, and a counter wide enough to reach it.
    localparam int RESULT_CAP = 8;
    localparam int CNT_W      = 4;

    // Register indexes (word address bit 2 on the config port).
    localparam logic REG_LINK = 1'b0;
    localparam logic REG_GAP  = 1'b1;

    // Input action codes.
    localparam logic ACT_QUEUE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Result kind codes.
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_SEND   = 1'b1;

    typedef enum logic [1:0] {
        CMD_QUEUE,
        CMD_REJECT,
        CMD_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t      op;
        logic [31:0]  now_ms;
        logic [10:0]  frame_len;
        logic [7:0]   copies;
    } cmd_t;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_port_t;

    typedef struct packed {
        logic         strobe;
        logic         kind;
        logic         accepted;
        logic [2:0]   slot;
        logic [10:0]  send_len;
        logic         last;
    } res_t;

endpackage

// File: rtl/core/tss_front.sv
module tss_front
    import tss_pkg::*;
#(
    parameter int FRAME_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        action,
    input  logic [31:0] now_ms,
    input  logic [10:0] frame_len,
    input  logic [7:0]  copies,
    input  logic        link_ready,
    input  logic        pop,
    output logic        busy,
    output cmd_port_t   head
);

    localparam int DEPTH = 2;

    cmd_t        entry_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    logic        accept;
    logic        push;
    logic        bad_len;
    cmd_t        cmd_in;

    assign busy   = (count_reg == 2'(DEPTH));
    assign accept = start && !busy;

    // Classify the item; drop ticks while the link is down.
    always_comb
    begin
        bad_len = (frame_len == 11'd0) || (frame_len > 11'(FRAME_BYTES))
                  || (copies == 8'd0);
        cmd_in.now_ms    = now_ms;
        cmd_in.frame_len = frame_len;
        cmd_in.copies    = copies;
        if (action == ACT_TICK)
        begin
            cmd_in.op = CMD_TICK;
        end
        else if (bad_len)
        begin
            cmd_in.op = CMD_REJECT;
        end
        else
        begin
            cmd_in.op = CMD_QUEUE;
        end
        push = accept && !((action == ACT_TICK) && !link_ready);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

// File: rtl/core/tss_back.sv
module tss_back
    import tss_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_port_t   head,
    input  logic [15:0] gap,
    output logic        pop,
    output res_t        res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   cursor_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [31:0]        now_reg;
    logic [CNT_W-1:0]   found_reg;
    logic               pend_valid_reg;
    logic [IDX_W-1:0]   pend_slot_reg;
    logic [10:0]        pend_len_reg;
    logic [SLOTS-1:0]   valid_reg;
    res_t               res_reg;
    res_t               res_next;

    // Slot store; read data registered.
    logic [10:0]        len_mem [SLOTS];
    logic [7:0]         cps_mem [SLOTS];
    logic [31:0]        due_mem [SLOTS];
    logic [10:0]        rd_len_reg;
    logic [7:0]         rd_cps_reg;
    logic [31:0]        rd_due_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               we_queue;
    logic               we_walk;
    logic [7:0]         wr_cps;
    logic [31:0]        wr_due;
    logic [7:0]         cur_cps;
    logic [31:0]        diff;
    logic               hit;
    logic               walk_end;

    assign pop = (state_reg == ST_IDLE) && head.valid;

    always_comb
    begin
        cur_cps  = valid_reg[idx_reg] ? rd_cps_reg : 8'd0;
        diff     = now_reg - rd_due_reg;
        hit      = (state_reg == ST_WALK) && (cur_cps != 8'd0) && !diff[31];
        walk_end = (idx_reg == LAST_IDX)
                   || (hit && (found_reg == CNT_W'(RESULT_CAP - 1)));

        we_queue = pop && (head.cmd.op == CMD_QUEUE);
        we_walk  = hit;
        wr_addr  = we_queue ? cursor_reg : idx_reg;
        wr_cps   = we_queue ? head.cmd.copies : (cur_cps - 8'd1);
        wr_due   = we_queue ? (head.cmd.now_ms + 32'(gap)) : (rd_due_reg + 32'(gap));

        // Fetch the next slot while the current one is judged.
        if ((state_reg == ST_WALK) && (idx_reg != LAST_IDX))
        begin
            rd_addr = idx_reg + IDX_W'(1);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Result for the next cycle; strobe stays low unless something is owed.
    // Hold one send back so the final one can carry last.
    always_comb
    begin
        res_next = '0;
        if (we_queue)
        begin
            res_next = '{strobe: 1'b1, kind: KIND_ANSWER,
                         accepted: 1'b1, slot: 3'(cursor_reg),
                         send_len: head.cmd.frame_len, last: 1'b1};
        end
        else if (pop && (head.cmd.op == CMD_REJECT))
        begin
            res_next = '{strobe: 1'b1, kind: KIND_ANSWER,
                         accepted: 1'b0, slot: 3'd0,
                         send_len: head.cmd.frame_len, last: 1'b1};
        end
        else if (hit && pend_valid_reg)
        begin
            res_next = '{strobe: 1'b1, kind: KIND_SEND,
                         accepted: 1'b1, slot: 3'(pend_slot_reg),
                         send_len: pend_len_reg, last: 1'b0};
        end
        else if ((state_reg == ST_FLUSH) && pend_valid_reg)
        begin
            res_next = '{strobe: 1'b1, kind: KIND_SEND,
                         accepted: 1'b1, slot: 3'(pend_slot_reg),
                         send_len: pend_len_reg, last: 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_queue)
        begin
            len_mem[wr_addr] <= head.cmd.frame_len;
        end
        if (we_queue || we_walk)
        begin
            cps_mem[wr_addr] <= wr_cps;
            due_mem[wr_addr] <= wr_due;
        end
        rd_len_reg <= len_mem[rd_addr];
        rd_cps_reg <= cps_mem[rd_addr];
        rd_due_reg <= due_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            idx_reg        <= '0;
            now_reg        <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_len_reg   <= '0;
            valid_reg      <= '0;
            res_reg        <= '0;
        end
        else
        begin
            res_reg <= res_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (head.cmd.op)
                            CMD_QUEUE:
                            begin
                                valid_reg[cursor_reg] <= 1'b1;
                                cursor_reg <= (cursor_reg == LAST_IDX) ? '0
                                              : cursor_reg + IDX_W'(1);
                            end
                            CMD_REJECT:
                            begin
                                state_reg <= ST_IDLE;
                            end
                            CMD_TICK:
                            begin
                                now_reg        <= head.cmd.now_ms;
                                idx_reg        <= '0;
                                found_reg      <= '0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= ST_WALK;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (hit)
                    begin
                        found_reg      <= found_reg + CNT_W'(1);
                        pend_valid_reg <= 1'b1;
                        pend_slot_reg  <= idx_reg;
                        pend_len_reg   <= rd_len_reg;
                    end
                    if (walk_end)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_FLUSH:
                begin
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

// File: rtl/core/timed_resend_slot_scheduler.sv
// Timed resend slot scheduler. An item is taken on a clock edge with start high
// and busy low; a two-entry command queue sits between the intake and the slot
// engine, so busy rises only when two items are waiting. A queue item taken while
// the engine is free passes its queue entry and then the result register before
// it is answered. A tick walks the slot store one slot per cycle through its
// single read port: it holds the engine for a start step, a step per slot walked
// and a flush step, so the engine takes one queue item per cycle only
// while no tick holds it. Every result shows on the result ports for exactly one
// cycle with strobe high and must be taken then; there is no back pressure. A
// tick sends at most eight frames, and the final send of a tick carries last.
// Ticks taken while link_ready is low are dropped and give no result. No
// clearing pass is needed after reset: slot counts read as zero until written.
module timed_resend_slot_scheduler
    import tss_pkg::*;
#(
    parameter int SLOTS       = 8,
    parameter int FRAME_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] now_ms,
    input  logic [10:0] frame_len,
    input  logic [7:0]  copies,
    // result channel
    output logic        strobe,
    output logic        kind,
    output logic        accepted,
    output logic [2:0]  slot,
    output logic [10:0] send_len,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        link_ready_reg;
    logic [15:0] gap_reg;
    logic        cfg_wr;
    logic        pop;
    cmd_port_t   head;
    res_t        res;

    // Registers sit at byte 0 (link_ready) and byte 4 (resend_gap_ms);
    // bit 2 of the address selects between them.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_ready_reg <= 1'b0;
            gap_reg        <= 16'd100;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_GAP)
            begin
                gap_reg <= pwdata[15:0];
            end
            else
            begin
                link_ready_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GAP) ? {16'd0, gap_reg} : {31'd0, link_ready_reg};

    // Intake: classify items and hold them until the engine takes them.
    tss_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .now_ms     (now_ms),
        .frame_len  (frame_len),
        .copies     (copies),
        .link_ready (link_ready_reg),
        .pop        (pop),
        .busy       (busy),
        .head       (head)
    );

    // Slot engine: fill slots and walk them on ticks.
    tss_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .gap   (gap_reg),
        .pop   (pop),
        .res   (res)
    );

    assign strobe   = res.strobe;
    assign kind     = res.kind;
    assign accepted = res.accepted;
    assign slot     = res.slot;
    assign send_len = res.send_len;
    assign last     = res.last;

endmodule

// File: rtl/core/tss_checker.sv
`include "assert_macros.svh"

module tss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       kind,
    input logic       accepted,
    input logic [2:0] slot,
    input logic       last
);

    // A queue answer is always the only result of its item.
    `TSS_ASSERT_IMP(a_answer_last, strobe && !kind, last)
    // Sends are never rejected.
    `TSS_ASSERT_IMP(a_send_taken, strobe && kind, accepted)
    // A rejection is a queue answer naming slot zero.
    `TSS_ASSERT_IMP(a_reject_form, strobe && !accepted, !kind && (slot == 3'd0))
    // The queue fills only after an item came in.
    `TSS_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start))

endmodule

bind timed_resend_slot_scheduler tss_checker u_tss_checker (.*);

// File: test/testbench.sv
module testbench
    import tss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the slot ring under test.
    localparam int SLOTS       = 8;
    localparam int FRAME_BYTES = 256;

    // A tick holds the engine for a start step, a step per slot and a flush step,
    // and the intake queue holds two more items behind it, so this many quiet
    // cycles cover any tick that gave no result before the block is called idle.
    localparam int SETTLE_CYCLES = 3 * (SLOTS + 2) + 10;

    // One result as seen on the result ports.
    typedef struct packed {
        logic        kind;
        logic        accepted;
        logic [2:0]  slot;
        logic [10:0] send_len;
        logic        last;
    } slot_result_t;

    // One row of the directed stimulus: either an item or a register write.
    typedef struct {
        bit           is_cfg;
        logic         act;
        logic [31:0]  now;
        logic [10:0]  len;
        logic [7:0]   cps;
        bit           typed;
        slot_result_t want;
        logic         sel;
        logic [31:0]  value;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = ACT_QUEUE;
    logic [31:0] now_ms = '0;
    logic [10:0] frame_len = '0;
    logic [7:0]  copies = '0;
    logic        strobe;
    logic        kind;
    logic        accepted;
    logic [2:0]  slot;
    logic [10:0] send_len;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block: configuration and the slot ring.
    logic        link_up = 1'b0;
    logic [15:0] gap_ms = 16'd100;
    logic [2:0]  ring_cursor = '0;
    logic [7:0]  copies_left [SLOTS];
    logic [31:0] due_ms [SLOTS];
    logic [10:0] stored_len [SLOTS];

    // Results still owed by the block, oldest first.
    slot_result_t awaited [$];
    int           mismatches = 0;

    plan_row_t    plan [$];

    timed_resend_slot_scheduler #(
        .SLOTS       (SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .now_ms    (now_ms),
        .frame_len (frame_len),
        .copies    (copies),
        .strobe    (strobe),
        .kind      (kind),
        .accepted  (accepted),
        .slot      (slot),
        .send_len  (send_len),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Advance the shadow ring by one accepted item and queue the results it owes.
    // A queue item always gets exactly one answer; a tick walks the slots in order
    // and owes one send per due live slot, at most RESULT_CAP, last on the final one.
    function automatic void schedule_item(input logic act, input logic [31:0] now,
                                          input logic [10:0] len, input logic [7:0] cps);
        slot_result_t r;
        slot_result_t held;
        bit           holding;
        int           sent;
        logic [31:0]  lag;

        if (act == ACT_QUEUE)
        begin
            r.kind     = KIND_ANSWER;
            r.send_len = len;
            r.last     = 1'b1;
            if (len == 0 || len > FRAME_BYTES || cps == 0)
            begin
                // Rejected: slot reads zero, ring untouched.
                r.accepted = 1'b0;
                r.slot     = '0;
            end
            else
            begin
                r.accepted                = 1'b1;
                r.slot                    = ring_cursor;
                stored_len[ring_cursor]   = len;
                copies_left[ring_cursor]  = cps;
                due_ms[ring_cursor]       = now + {16'd0, gap_ms};
                ring_cursor               = 3'((int'(ring_cursor) + 1) % SLOTS);
            end
            awaited.push_back(r);
            return;
        end

        // Drop ticks while the link is down.
        if (!link_up)
        begin
            return;
        end

        sent    = 0;
        holding = 1'b0;
        for (int i = 0; i < SLOTS && sent < RESULT_CAP; i++)
        begin
            if (copies_left[i] == 0)
            begin
                continue;
            end
            // Wrap-safe check: due when now - due is not negative.
            lag = now - due_ms[i];
            if (lag[31])
            begin
                continue;
            end
            if (holding)
            begin
                awaited.push_back(held);
            end
            held.kind     = KIND_SEND;
            held.accepted = 1'b1;
            held.slot     = 3'(i);
            held.send_len = stored_len[i];
            held.last     = 1'b0;
            holding       = 1'b1;
            sent++;
            copies_left[i] = copies_left[i] - 8'd1;
            due_ms[i]      = due_ms[i] + {16'd0, gap_ms};
        end
        if (holding)
        begin
            held.last = 1'b1;
            awaited.push_back(held);
        end
    endfunction

    // Present one item, idling the sender beforehand at the given percentage, and
    // hold it until the block takes it. Return at the edge that took it, with start
    // still high, so the next call lowers or re-raises it exactly once.
    // A typed row replaces the predicted answer with the one written in the table.
    task automatic issue_cmd(input logic act, input logic [31:0] now,
                             input logic [10:0] len, input logic [7:0] cps,
                             input int idle_pct, input bit typed,
                             input slot_result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        now_ms    <= now;
        frame_len <= len;
        copies    <= cps;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        schedule_item(act, now, len, cps);
        if (typed)
        begin
            void'(awaited.pop_back());
            awaited.push_back(want);
        end
    endtask

    // Lower start and wait until every owed result is in, then give any silent
    // tick still in the engine time to finish.
    task automatic settle_idle();
        start <= 1'b0;
        while (awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register over the config port, read it back, then update the shadow.
    task automatic write_reg(input logic sel, input logic [31:0] value);
        logic [31:0] mask;

        mask    = (sel == REG_LINK) ? 32'h1 : 32'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);

        // Read back: setup then access, sample prdata at the edge that ends access.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if ((prdata & mask) !== (value & mask))
        begin
            flag_mismatch($sformatf("register %0d reads %h, wrote %h",
                                    sel, prdata & mask, value & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;

        if (sel == REG_LINK)
        begin
            link_up = value[0];
        end
        else
        begin
            gap_ms = value[15:0];
        end
    endtask

    function automatic plan_row_t item_row(input logic act, input logic [31:0] now,
                                           input logic [10:0] len, input logic [7:0] cps);
        plan_row_t row;

        row        = '{default: '0};
        row.act    = act;
        row.now    = now;
        row.len    = len;
        row.cps    = cps;
        return row;
    endfunction

    // Queue item whose answer is plain from the fields and the cursor.
    function automatic plan_row_t answer_row(input logic [31:0] now, input logic [10:0] len,
                                             input logic [7:0] cps, input logic acc,
                                             input logic [2:0] at);
        plan_row_t row;

        row       = item_row(ACT_QUEUE, now, len, cps);
        row.typed = 1'b1;
        row.want  = '{kind: KIND_ANSWER, accepted: acc, slot: at, send_len: len, last: 1'b1};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic sel, input logic [31:0] value);
        plan_row_t row;

        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.sel    = sel;
        row.value  = value;
        return row;
    endfunction

    // Check every strobed result against the oldest owed one, field by field.
    always @(posedge clk)
    begin : result_watch
        slot_result_t want;

        if (rst_n && strobe)
        begin
            if (awaited.size() == 0)
            begin
                flag_mismatch($sformatf("result with none owed: kind %0b slot %0d len %0d",
                                        kind, slot, send_len));
            end
            else
            begin
                want = awaited.pop_front();
                if (kind !== want.kind || accepted !== want.accepted ||
                    slot !== want.slot || send_len !== want.send_len ||
                    last !== want.last)
                begin
                    flag_mismatch($sformatf(
                        "got kind %0b acc %0b slot %0d len %0d last %0b, want %0b %0b %0d %0d %0b",
                        kind, accepted, slot, send_len, last,
                        want.kind, want.accepted, want.slot, want.send_len, want.last));
                end
            end
        end
    end

    // Hard stop if the run hangs: far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        // Per-phase settings of the random part: sender idle percentage and
        // register values; the extremes of the gap and a link-down phase are in here.
        int           seg_idle [6];
        int           seg_gap  [6];
        int           seg_link [6];
        int           seg;
        int           n;
        int           pick;
        int           stride;
        logic [31:0]  clock_ms;
        logic [10:0]  len;
        logic [7:0]   cps;

        seg_idle = '{25, 25, 78, 78, 0, 0};
        seg_gap  = '{1, 65535, 0, 37, 100, 5};
        seg_link = '{1, 1, 1, 0, 1, 1};

        for (int i = 0; i < SLOTS; i++)
        begin
            copies_left[i] = '0;
            due_ms[i]      = '0;
            stored_len[i]  = '0;
        end

        // Directed part. Starts from reset: link down, gap 100, cursor at slot 0.
        plan.push_back(answer_row(32'd0, 11'd1, 8'd1, 1'b1, 3'd0));
        // Tick while the link is down: no result.
        plan.push_back(item_row(ACT_TICK, 32'd1000, 11'd0, 8'd0));
        // Rejections: empty frame, oversize frames, zero copies.
        plan.push_back(answer_row(32'd0, 11'd0, 8'd5, 1'b0, 3'd0));
        plan.push_back(answer_row(32'd0, 11'(FRAME_BYTES + 1), 8'd1, 1'b0, 3'd0));
        plan.push_back(answer_row(32'd0, 11'd2047, 8'd255, 1'b0, 3'd0));
        plan.push_back(answer_row(32'd0, 11'd5, 8'd0, 1'b0, 3'd0));
        // Largest legal frame and copy count, queued at the last ms before wrap.
        plan.push_back(answer_row(32'hFFFF_FFFF, 11'(FRAME_BYTES), 8'd255, 1'b1, 3'd1));
        plan.push_back(answer_row(32'd0, 11'd1024, 8'd1, 1'b0, 3'd0));
        plan.push_back(cfg_row(REG_LINK, 32'd1));
        // Nothing due yet, then exactly due across the wrap, then exactly due.
        plan.push_back(item_row(ACT_TICK, 32'd50, 11'd0, 8'd0));
        plan.push_back(item_row(ACT_TICK, 32'd99, 11'd0, 8'd0));
        plan.push_back(item_row(ACT_TICK, 32'd100, 11'd0, 8'd0));
        // Fill the rest of the ring, then wrap the cursor back to slot 0.
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd16, 8'd2));
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd32, 8'd2));
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd64, 8'd2));
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd128, 8'd2));
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd200, 8'd2));
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd255, 8'd2));
        plan.push_back(item_row(ACT_TICK, 32'd300, 11'd0, 8'd0));
        plan.push_back(item_row(ACT_QUEUE, 32'd200, 11'd1, 8'd3));
        // Every slot due at once: the full burst of eight sends.
        plan.push_back(item_row(ACT_TICK, 32'd400, 11'd0, 8'd0));
        plan.push_back(cfg_row(REG_GAP, 32'd65535));
        plan.push_back(item_row(ACT_QUEUE, 32'd1000, 11'd100, 8'd2));
        plan.push_back(item_row(ACT_TICK, 32'd66534, 11'd0, 8'd0));
        plan.push_back(item_row(ACT_TICK, 32'd66535, 11'd0, 8'd0));

        // Hold reset low, then release it on a rising edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
            begin
                settle_idle();
                write_reg(plan[k].sel, plan[k].value);
            end
            else
            begin
                issue_cmd(plan[k].act, plan[k].now, plan[k].len, plan[k].cps, 25,
                          plan[k].typed, plan[k].want);
            end
        end

        // Random part: mostly a time line that moves forward, with frames queued at
        // the current time and ticks stepping up to two gaps ahead; a small share of
        // noise with arbitrary times and fields.
        clock_ms = 32'd70000;
        for (seg = 0; seg < 6; seg++)
        begin
            settle_idle();
            write_reg(REG_LINK, 32'(seg_link[seg]));
            write_reg(REG_GAP, 32'(seg_gap[seg]));
            stride = (seg_gap[seg] == 0) ? 1 : seg_gap[seg];
            // Jump close to the 32-bit wrap so large gaps carry due times across it.
            if (seg == 1)
            begin
                clock_ms = 32'hFFF0_0000;
            end
            for (n = 0; n < 55; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    if ($urandom_range(99) < 85)
                    begin
                        len = 11'($urandom_range(FRAME_BYTES, 1));
                    end
                    else if ($urandom_range(1))
                    begin
                        len = '0;
                    end
                    else
                    begin
                        len = 11'($urandom_range(2047, FRAME_BYTES + 1));
                    end
                    pick = $urandom_range(99);
                    if (pick < 80)
                    begin
                        cps = 8'($urandom_range(4, 1));
                    end
                    else if (pick < 95)
                    begin
                        cps = 8'($urandom_range(255, 5));
                    end
                    else
                    begin
                        cps = '0;
                    end
                    issue_cmd(ACT_QUEUE, clock_ms, len, cps, seg_idle[seg], 1'b0, '0);
                end
                else if (pick < 92)
                begin
                    clock_ms = clock_ms + 32'($urandom_range(2 * stride, 0));
                    issue_cmd(ACT_TICK, clock_ms, 11'($urandom), 8'($urandom),
                              seg_idle[seg], 1'b0, '0);
                end
                else
                begin
                    issue_cmd(1'($urandom_range(1)), $urandom, 11'($urandom_range(2047)),
                              8'($urandom_range(255)), seg_idle[seg], 1'b0, '0);
                end
            end
        end

        // Drain: wait for every owed result, then watch a while for strays.
        start <= 1'b0;
        while (awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
